// File: rtl/core/rctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctd_pkg
// types, constants and the nibble symbol table of the run-coded text decoder
// ----------------------------------------------------------------------------
package rctd_pkg;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_PACKED  = 2'd2
  } run_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } result_t;

  localparam logic [7:0] HdrNewline = 8'hFF;
  localparam logic [7:0] SymCr      = 8'h0D;
  localparam logic [7:0] LitMask    = 8'h33;

  function automatic logic [7:0] nibble_sym(input logic [3:0] nib);
    logic [7:0] sym;
    case (nib)
      4'h0:    sym = 8'h00;
      4'h1:    sym = 8'h20;
      4'h2:    sym = 8'h2D;
      4'h3:    sym = 8'h2E;
      4'h4:    sym = 8'h30;
      4'h5:    sym = 8'h31;
      4'h6:    sym = 8'h32;
      4'h7:    sym = 8'h33;
      4'h8:    sym = 8'h34;
      4'h9:    sym = 8'h35;
      4'hA:    sym = 8'h36;
      4'hB:    sym = 8'h37;
      4'hC:    sym = 8'h38;
      4'hD:    sym = 8'h39;
      4'hE:    sym = 8'h0A;
      default: sym = 8'h00;
    endcase
    return sym;
  endfunction

endpackage

// File: rtl/core/run_coded_text_decoder.sv
`timescale 1ns / 1ps
// results are registered: a result is offered in the cycle after its item is accepted
// throughput (one-result-per-cycle output): one item per cycle for header and literal
// bytes with out_ready_i high; two-symbol packed bytes stall input until one is taken
// reset: rst_ni async low, mode returns to header, count to zero, result buffer empty
// ----------------------------------------------------------------------------
// run_coded_text_decoder
// decodes a run-coded byte stream into text, up to two characters per item
// ----------------------------------------------------------------------------
module run_coded_text_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] coded_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] text_byte_o,
  output logic       last_of_item_o
);
  import rctd_pkg::*;

  run_mode_e   mode_q, mode_d;
  logic [6:0]  left_q, left_d;
  result_t     r0_q, r0_d, r1_q, r1_d;
  logic [1:0]  cnt_q, cnt_d;

  result_t     res0, res1;
  logic [1:0]  n_res;
  logic [7:0]  hi_sym, lo_sym;
  logic        in_acc, out_acc;

  assign out_valid_o    = (cnt_q != 2'd0);
  assign text_byte_o    = r0_q.text_byte;
  assign last_of_item_o = r0_q.last;
  assign out_acc        = out_valid_o && out_ready_i;
  // take an item only when the buffer will be empty after this cycle
  assign in_ready_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_acc         = in_valid_i && in_ready_o;

  assign hi_sym = nibble_sym(coded_byte_i[7:4]);
  assign lo_sym = nibble_sym(coded_byte_i[3:0]);

  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    res0   = '{text_byte: 8'h00, last: 1'b1};
    res1   = '{text_byte: lo_sym, last: 1'b1};
    n_res  = 2'd0;
    case (mode_q)
      MODE_LITERAL: begin
        res0   = '{text_byte: coded_byte_i ^ LitMask, last: 1'b1};
        n_res  = 2'd1;
        left_d = left_q - 7'd1;
        if (left_d == 7'd0) mode_d = MODE_HEADER;
      end
      MODE_PACKED: begin
        if ((left_q <= 7'd1) || (lo_sym == 8'h00)) begin
          res0   = '{text_byte: hi_sym, last: 1'b1};
          n_res  = 2'd1;
          mode_d = MODE_HEADER;
          left_d = 7'd0;
        end else begin
          res0   = '{text_byte: hi_sym, last: 1'b0};
          n_res  = 2'd2;
          left_d = left_q - 7'd2;
          if (left_d == 7'd0) mode_d = MODE_HEADER;
        end
      end
      default: begin
        mode_d = MODE_HEADER;
        if (coded_byte_i == HdrNewline) begin
          left_d = 7'd0;
          res0   = '{text_byte: SymCr, last: 1'b1};
          n_res  = 2'd1;
        end else begin
          left_d = coded_byte_i[6:0];
          if (left_d != 7'd0) mode_d = coded_byte_i[7] ? MODE_PACKED : MODE_LITERAL;
        end
      end
    endcase
  end

  always_comb begin
    r0_d  = r0_q;
    r1_d  = r1_q;
    cnt_d = cnt_q;
    if (out_acc) begin
      r0_d  = r1_q;
      cnt_d = cnt_q - 2'd1;
    end
    if (in_acc) begin
      r0_d  = res0;
      r1_d  = res1;
      cnt_d = n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEADER;
      left_q <= 7'd0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        mode_q <= mode_d;
        left_q <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result count out of range");

  a_run_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_q != MODE_HEADER) |=> cnt_q != 2'd0)
    else $error("run item gave no result");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_HEADER) |-> (left_q != 7'd0))
    else $error("run mode with zero count");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!r0_q.last && r1_q.last))
    else $error("bad last flags on result pair");
`endif

endmodule
